@@ hw/rtl/frame_pacing_predictor_assert.svh @@
// Assertion macros for the frame pacing predictor.
`ifndef FRAME_PACING_PREDICTOR_ASSERT_SVH
`define FRAME_PACING_PREDICTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define FPP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FPP_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FPP_ASSERT(lbl, clk, rst_n, prop, msg)
`define FPP_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

@@ hw/rtl/fpp_pkg.sv @@
// Shared types and constants of the frame pacing predictor.
package fpp_pkg;

    localparam int FRAME_SLOTS = 16;
    localparam int SLOT_W      = $clog2(FRAME_SLOTS);

    localparam int DIV_STEPS   = 64;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [2:0] OP_PREDICT = 3'd0;
    localparam logic [2:0] OP_WAKE    = 3'd1;
    localparam logic [2:0] OP_OTHER   = 3'd2;
    localparam logic [2:0] OP_DELIV   = 3'd3;
    localparam logic [2:0] OP_GPU     = 3'd4;
    localparam logic [2:0] OP_INFO    = 3'd5;

    localparam logic [26:0] PERIOD_MIN   = 27'd1000000;
    localparam logic [26:0] PERIOD_MAX   = 27'd100000000;
    localparam logic [26:0] PERIOD_RESET = 27'd10000000;
    localparam logic [22:0] MARGIN_MIN   = 23'd500000;
    localparam logic [22:0] MARGIN_MAX   = 23'd5000000;
    localparam logic [22:0] MARGIN_RESET = 23'd1500000;
    localparam logic [20:0] MS_NS        = 21'd1000000;
    localparam logic [20:0] OVERHEAD_MAX = 21'd1500000;

    // Reciprocal of ten; exact for operands below 2^32 with a shift of 35.
    localparam logic [31:0] RECIP10      = 32'hCCCCCCCD;
    localparam int          RECIP_SHIFT  = 35;

    typedef struct packed {
        logic [62:0] tag;
        logic [62:0] wake;
        logic [62:0] deliv;
    } t_slot;

endpackage

@@ hw/rtl/fpp_slot_ram.sv @@
// Frame slot ring memory with registered read and per-entry valid bits.
module fpp_slot_ram
    import fpp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [SLOT_W-1:0] i_wr_addr,
    input  t_slot             i_wr_data,
    input  logic              i_rd_en,
    input  logic [SLOT_W-1:0] i_rd_addr,
    output t_slot             o_rd_data
);

    t_slot                  r_mem [FRAME_SLOTS];
    logic [FRAME_SLOTS-1:0] r_valid;
    t_slot                  r_rd_data;
    logic                   r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // An entry never written reads as zero, which is its reset content.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

@@ hw/rtl/fpp_div.sv @@
// Restoring divider, one quotient bit per cycle, that returns the remainder.
module fpp_div
    import fpp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [26:0] i_divisor,
    output logic        o_done,
    output logic [26:0] o_rem
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [63:0]          r_dvd;
    logic [26:0]          r_rem;
    logic [26:0]          r_div;
    logic [27:0]          trial;
    logic                 ge;

    assign trial = {r_rem, r_dvd[63]};
    assign ge    = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[62:0], 1'b0};
                r_rem <= ge ? 27'(trial - {1'b0, r_div}) : trial[26:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ hw/rtl/frame_pacing_predictor.sv @@
// Top level of the frame pacing predictor: sequencer, timing state and result register.
//
//  Channel   Ports                                   Handshake
//  --------  --------------------------------------  ------------------------------
//  request   i_op, i_time_ns, i_frame_number, ...    taken when start & !busy
//  result    o_prediction_valid ... o_app_time_ns    o_result_valid, one cycle
//  config    i_cfg_wdata (min_margin_ns)             written when i_cfg_we
//
// A predict request makes up to two passes through the shared
// 64-step remainder divider (phase lock, then catch-up when late).
// Marks read their slot, and a GPU mark that finds both times set also updates the
// averages; the slot index is the low bits of the frame number.
// Info and other requests go from idle straight to the result state.
// Reset is synchronous and active low; the slot ring clears through valid bits.
// The receiver cannot stall: each result shows for exactly one cycle.
`include "frame_pacing_predictor_assert.svh"
module frame_pacing_predictor
    import fpp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_op,
    input  logic [62:0]        i_time_ns,
    input  logic [62:0]        i_frame_number,
    input  logic [62:0]        i_comp_display_ns,
    input  logic [26:0]        i_period_ns,
    input  logic signed [30:0] i_extra_ns,
    input  logic               i_cfg_we,
    input  logic [22:0]        i_cfg_wdata,
    output logic               o_result_valid,
    output logic               o_prediction_valid,
    output logic [62:0]        o_new_frame,
    output logic signed [63:0] o_wake_up_ns,
    output logic [62:0]        o_display_ns,
    output logic [26:0]        o_display_period_ns,
    output logic [20:0]        o_app_time_ns
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_IDX  = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_SM1  = 4'd3;
    localparam logic [3:0] S_SM2  = 4'd4;
    localparam logic [3:0] S_P1   = 4'd5;
    localparam logic [3:0] S_P2   = 4'd6;
    localparam logic [3:0] S_P3   = 4'd7;
    localparam logic [3:0] S_P4   = 4'd8;
    localparam logic [3:0] S_P5   = 4'd9;
    localparam logic [3:0] S_P6   = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    // Architectural state.
    logic [3:0]        r_state;
    logic [22:0]       r_margin;
    logic [62:0]       r_fc;
    logic [SLOT_W-1:0] r_fc_idx;
    logic [62:0]       r_comp;
    logic [63:0]       r_ideal;
    logic [26:0]       r_period;
    logic [20:0]       r_cpu;
    logic [20:0]       r_gpu;
    logic [29:0]       r_ctime;

    // Per-request working registers.
    logic [2:0]        r_op;
    logic [62:0]       r_time;
    logic [62:0]       r_fn;
    logic [SLOT_W-1:0] r_idx;
    logic [63:0]       r_ready;
    logic [31:0]       r_work;
    logic              r_snap;
    logic              r_neg;
    logic [63:0]       r_dvd;
    logic              r_limited;
    logic [20:0]       r_bc;
    logic [20:0]       r_bg;
    logic [63:0]       r_prod_c;
    logic [63:0]       r_prod_g;
    logic              r_neg_c;
    logic              r_neg_g;

    // Result register.
    logic              r_out_valid;
    logic              r_out_pv;
    logic [62:0]       r_out_frame;
    logic [63:0]       r_out_wake;
    logic [62:0]       r_out_disp;
    logic [26:0]       r_out_period;
    logic [20:0]       r_out_app;

    // Divider and slot memory hookup.
    logic              div_start;
    logic [63:0]       div_dividend;
    logic [26:0]       div_divisor;
    logic              div_done;
    logic [26:0]       div_rem;
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    t_slot             ram_wdata;
    logic              ram_re;
    t_slot             ram_rdata;

    // Predict arithmetic.
    logic [26:0]        half_p;
    logic [27:0]        p_1m;
    logic [20:0]        cc;
    logic [20:0]        cg;
    logic [31:0]        work;
    logic signed [28:0] max_pad;
    logic [31:0]        pad;
    logic [63:0]        ready;
    logic [63:0]        ud;
    logic [63:0]        mag;
    logic               snap;
    logic [63:0]        dvd_p2;
    logic [63:0]        off;
    logic signed [27:0] dfine;
    logic [26:0]        dmag;
    logic [26:0]        q_fine;
    logic [63:0]        ideal_p;
    logic               late;
    logic               limited;

    // Smoothing arithmetic.
    logic [20:0]        raw_c;
    logic [20:0]        raw_g;
    logic signed [22:0] d_c;
    logic signed [22:0] d_g;
    logic [22:0]        x_c;
    logic [22:0]        x_g;
    logic [22:0]        q_c;
    logic [22:0]        q_g;
    logic [22:0]        avg_c;
    logic [22:0]        avg_g;

    logic               hit;
    logic [22:0]        cfg_margin;
    logic [26:0]        in_period;

    function automatic logic [20:0] clamp_raw(input logic [63:0] v);
        logic signed [63:0] s;
        s = $signed(v);
        if (s > $signed(64'(OVERHEAD_MAX))) begin
            return OVERHEAD_MAX;
        end else if (s < $signed(64'(MS_NS))) begin
            return MS_NS;
        end
        return v[20:0];
    endfunction

    assign busy = (r_state != S_IDLE);
    assign hit  = (ram_rdata.tag == r_fn);

    assign cfg_margin = (i_cfg_wdata < MARGIN_MIN) ? MARGIN_MIN :
                        (i_cfg_wdata > MARGIN_MAX) ? MARGIN_MAX : i_cfg_wdata;
    assign in_period  = (i_period_ns < PERIOD_MIN) ? PERIOD_MIN :
                        (i_period_ns > PERIOD_MAX) ? PERIOD_MAX : i_period_ns;

    // The earliest ready time pads the current time by the expected work,
    // limited so that the margin still fits in one period.
    always_comb begin
        half_p  = r_period >> 1;
        p_1m    = {1'b0, r_period} - 28'(MS_NS);
        cc      = ({7'b0, r_cpu} < p_1m) ? r_cpu : p_1m[20:0];
        cg      = ({7'b0, r_gpu} < p_1m) ? r_gpu : p_1m[20:0];
        work    = 32'(cc) + 32'(cg) + 32'(r_ctime);
        max_pad = $signed({2'b0, r_period}) - $signed({6'b0, r_margin})
                  - $signed(29'(MS_NS));
        if (max_pad > 0) begin
            pad = (work < 32'(max_pad)) ? work : 32'(max_pad);
        end else begin
            pad = '0;
        end
        ready   = {1'b0, r_time} + 64'(pad);

        ud      = r_ideal - {1'b0, r_comp};
        mag     = ud[63] ? (64'd0 - ud) : ud;
        snap    = mag > 64'({r_period, 1'b0});
        dvd_p2  = snap ? (mag + 64'(half_p))
                       : (ud + 64'(half_p) + 64'(r_period) + 64'({r_period, 1'b0}));

        off     = r_dvd - 64'(div_rem);
        dfine   = $signed({1'b0, div_rem}) - $signed({1'b0, half_p});
        dmag    = dfine[27] ? 27'(-dfine) : dfine[26:0];
        q_fine  = 27'(r_prod_c >> RECIP_SHIFT);

        ideal_p = r_ideal + 64'(r_period);
        late    = $signed(r_ready) > $signed(r_ideal);
        limited = late && ($signed(r_ready) < $signed(ideal_p));
    end

    // Smoothing: floor of the difference over ten, via the reciprocal.
    always_comb begin
        raw_c = clamp_raw({1'b0, ram_rdata.deliv} - {1'b0, ram_rdata.wake});
        raw_g = clamp_raw({1'b0, r_time} - {1'b0, ram_rdata.deliv});
        d_c   = $signed({2'b0, r_bc}) - $signed({2'b0, r_cpu});
        d_g   = $signed({2'b0, r_bg}) - $signed({2'b0, r_gpu});
        x_c   = d_c[22] ? 23'(-d_c) + 23'd9 : d_c;
        x_g   = d_g[22] ? 23'(-d_g) + 23'd9 : d_g;
        q_c   = 23'(r_prod_c >> RECIP_SHIFT);
        q_g   = 23'(r_prod_g >> RECIP_SHIFT);
        avg_c = r_neg_c ? ({2'b0, r_cpu} - q_c) : ({2'b0, r_cpu} + q_c);
        avg_g = r_neg_g ? ({2'b0, r_gpu} - q_g) : ({2'b0, r_gpu} + q_g);
    end

    // Divider requests: phase lock and catch-up.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = r_period;
        case (r_state)
            S_P2: begin
                div_start    = 1'b1;
                div_dividend = dvd_p2;
            end
            S_P5: begin
                div_start    = late;
                div_dividend = r_ready - r_ideal;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // Slot memory requests.
    always_comb begin
        ram_re    = (r_state == S_IDX);
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = ram_rdata;
        case (r_state)
            S_P1: begin
                ram_we          = 1'b1;
                ram_waddr       = (r_fc_idx == SLOT_W'(FRAME_SLOTS - 1)) ? '0
                                  : r_fc_idx + 1'b1;
                ram_wdata.tag   = r_fc + 1'b1;
                ram_wdata.wake  = '0;
                ram_wdata.deliv = '0;
            end
            S_RD: begin
                if (r_op == OP_WAKE) begin
                    ram_we         = hit;
                    ram_wdata.wake = r_time;
                end else if (r_op == OP_DELIV) begin
                    ram_we          = hit;
                    ram_wdata.deliv = r_time;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_margin    <= MARGIN_RESET;
            r_fc        <= '0;
            r_fc_idx    <= '0;
            r_comp      <= '0;
            r_ideal     <= '0;
            r_period    <= PERIOD_RESET;
            r_cpu       <= '0;
            r_gpu       <= '0;
            r_ctime     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                r_margin <= cfg_margin;
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op   <= i_op;
                        r_time <= i_time_ns;
                        r_fn   <= i_frame_number;
                        case (i_op)
                            OP_PREDICT: r_state <= S_P1;
                            OP_WAKE, OP_DELIV, OP_GPU: begin
                                r_idx   <= i_frame_number[SLOT_W-1:0];
                                r_state <= S_IDX;
                            end
                            OP_INFO: begin
                                r_comp   <= i_comp_display_ns;
                                r_period <= in_period;
                                r_ctime  <= i_extra_ns[30] ? '0 : i_extra_ns[29:0];
                                r_state  <= S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_IDX: begin
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_bc <= raw_c;
                    r_bg <= raw_g;
                    if (r_op == OP_GPU && hit && ram_rdata.wake != '0 &&
                        ram_rdata.deliv != '0) begin
                        r_state <= S_SM1;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_SM1: begin
                    r_prod_c <= 64'(x_c) * 64'(RECIP10);
                    r_prod_g <= 64'(x_g) * 64'(RECIP10);
                    r_neg_c  <= d_c[22];
                    r_neg_g  <= d_g[22];
                    r_state  <= S_SM2;
                end
                S_SM2: begin
                    r_cpu   <= (r_cpu == '0) ? r_bc : avg_c[20:0];
                    r_gpu   <= (r_gpu == '0) ? r_bg : avg_g[20:0];
                    r_state <= S_DONE;
                end
                S_P1: begin
                    r_fc     <= r_fc + 1'b1;
                    r_fc_idx <= ram_waddr;
                    r_work   <= work;
                    r_ready  <= ready;
                    r_ideal  <= r_ideal + 64'(r_period);
                    r_state  <= S_P2;
                end
                S_P2: begin
                    r_snap  <= snap;
                    r_neg   <= ud[63];
                    r_dvd   <= dvd_p2;
                    r_state <= S_P3;
                end
                S_P3: begin
                    if (div_done) begin
                        if (r_snap) begin
                            // Snap to the nearest whole period of the compositor time.
                            r_ideal <= {1'b0, r_comp} + (r_neg ? (64'd0 - off) : off);
                            r_state <= S_P5;
                        end else begin
                            r_prod_c <= 64'(dmag) * 64'(RECIP10);
                            r_neg    <= dfine[27];
                            r_state  <= S_P4;
                        end
                    end
                end
                S_P4: begin
                    // Remove a tenth of the phase error, truncated toward zero.
                    r_ideal <= r_neg ? (r_ideal + 64'(q_fine)) : (r_ideal - 64'(q_fine));
                    r_state <= S_P5;
                end
                S_P5: begin
                    r_limited <= limited;
                    r_dvd     <= r_ready - r_ideal;
                    r_state   <= late ? S_P6 : S_DONE;
                end
                S_P6: begin
                    if (div_done) begin
                        // Advance by the least whole number of periods that reaches or passes ready.
                        r_ideal <= r_ideal + r_dvd +
                                   ((div_rem != '0) ? 64'(r_period - div_rem) : 64'd0);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_out_valid  <= 1'b1;
                    r_out_app    <= (r_cpu > r_gpu) ? r_cpu : r_gpu;
                    r_out_pv     <= 1'b0;
                    r_out_frame  <= '0;
                    r_out_wake   <= '0;
                    r_out_disp   <= '0;
                    r_out_period <= '0;
                    if (r_op == OP_PREDICT) begin
                        r_out_pv     <= 1'b1;
                        r_out_frame  <= r_fc;
                        r_out_wake   <= r_limited ? {1'b0, r_time}
                                        : r_ideal - 64'(r_work) - 64'(r_margin);
                        r_out_disp   <= r_ideal[62:0];
                        r_out_period <= r_period;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    fpp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // Reads and writes of one slot never overlap: reads come only in S_IDX
    // and writes only in S_RD and S_P1, so no read meets a write.
    fpp_slot_ram u_slots (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (r_idx),
        .o_rd_data (ram_rdata)
    );

    assign o_result_valid      = r_out_valid;
    assign o_prediction_valid  = r_out_valid && r_out_pv;
    assign o_new_frame         = r_out_frame;
    assign o_wake_up_ns        = $signed(r_out_wake);
    assign o_display_ns        = r_out_disp;
    assign o_display_period_ns = r_out_period;
    assign o_app_time_ns       = r_out_app;

    `FPP_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "request not taken")
    `FPP_ASSERT(a_done_strobe, i_clk, i_rst_n, (r_state == S_DONE) |=> o_result_valid, "no result")
    `FPP_ASSERT(a_pred_strobe, i_clk, i_rst_n, o_prediction_valid |-> o_result_valid, "bad pred")
    `FPP_ASSERT(a_period_rng, i_clk, i_rst_n, (r_period >= PERIOD_MIN) && (r_period <= PERIOD_MAX), "period")
    `FPP_ASSERT_NR(a_reset_quiet, i_clk, !i_rst_n |=> !o_result_valid, "result after reset")

endmodule
